>>> hw/rtl/sdh_pkg.sv
package sdh_pkg;

   localparam int unsigned BLOCK_BYTES = 512;
   localparam int unsigned DUMMY_BYTES = 20;
   localparam int unsigned FRAME_BYTES = 7;
   localparam int unsigned CSD_BYTES   = 16;
   localparam int unsigned CRC_BYTES   = 2;

   localparam logic [7:0]  FILL_BYTE     = 8'hFF;
   localparam logic [7:0]  START_TOKEN   = 8'hFE;
   localparam logic [7:0]  CMD_BASE      = 8'h40;
   localparam logic [7:0]  CHK_CMD0      = 8'h95;
   localparam logic [7:0]  CHK_CMD8      = 8'h87;
   localparam logic [7:0]  CHK_OTHER     = 8'h01;
   localparam logic [7:0]  RSP_IDLE      = 8'h01;
   localparam logic [7:0]  RSP_ILLEGAL   = 8'h05;
   localparam logic [31:0] ARG_CMD8      = 32'h0000_01AA;
   localparam logic [31:0] ARG_ACMD41    = 32'h4000_0000;
   localparam logic [7:0]  RETRIES_RESET = 8'd10;

   localparam logic [7:0] IDX_CMD0   = 8'd0;
   localparam logic [7:0] IDX_CMD8   = 8'd8;
   localparam logic [7:0] IDX_CMD9   = 8'd9;
   localparam logic [7:0] IDX_CMD17  = 8'd17;
   localparam logic [7:0] IDX_ACMD41 = 8'd41;
   localparam logic [7:0] IDX_CMD55  = 8'd55;

   localparam logic [1:0] MODE_INIT = 2'd0;
   localparam logic [1:0] MODE_READ = 2'd1;
   localparam logic [1:0] MODE_BYTE = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ABSENT   = 2'd1;
   localparam logic [1:0] ST_CARD_ERR = 2'd2;
   localparam logic [1:0] ST_REJECTED = 2'd3;

   localparam logic [1:0] KIND_UNKNOWN = 2'd0;
   localparam logic [1:0] KIND_SC      = 2'd1;
   localparam logic [1:0] KIND_HC      = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   typedef enum logic [4:0] {
      PH_IDLE, PH_DUMMY, PH_CMD0_TX, PH_CMD0_RSP, PH_CMD8_TX, PH_CMD8_RSP,
      PH_CMD8_ECHO, PH_CMD55_TX, PH_CMD55_RSP, PH_ACMD41_TX, PH_ACMD41_RSP,
      PH_CMD9_TX, PH_CMD9_RSP, PH_CSD_WAIT, PH_CSD_DATA, PH_READ_TX,
      PH_READ_RSP, PH_READ_WAIT, PH_READ_DATA, PH_READ_CRC
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [9:0]  byte_count;
      logic [7:0]  retry_count;
      logic [1:0]  card_kind;
      logic [31:0] capacity;
      logic        protect;
      logic [31:0] argument;
      logic [21:0] csd;
   } state_type;

   typedef struct packed {
      logic [7:0]  send_byte;
      logic        send_valid;
      logic        chip_select;
      logic [7:0]  data_byte;
      logic        data_valid;
      logic        last;
      logic        done_res;
      logic [1:0]  status;
      logic [7:0]  reject_code;
      logic [1:0]  card_kind;
      logic [31:0] capacity_blocks;
      logic        write_protected;
   } rsp_type;

   function automatic logic [7:0] frame_byte(phase_type ph, logic [2:0] k,
                                             logic [31:0] arg);
      logic [7:0] idx;
      logic [7:0] chk;
      logic [7:0] b;
      chk = CHK_OTHER;
      case (ph)
         PH_CMD0_TX: begin
            idx = IDX_CMD0;
            chk = CHK_CMD0;
         end
         PH_CMD8_TX: begin
            idx = IDX_CMD8;
            chk = CHK_CMD8;
         end
         PH_CMD55_TX:  idx = IDX_CMD55;
         PH_ACMD41_TX: idx = IDX_ACMD41;
         PH_CMD9_TX:   idx = IDX_CMD9;
         default:      idx = IDX_CMD17;
      endcase
      case (k)
         3'd1:    b = CMD_BASE | idx;
         3'd2:    b = arg[31:24];
         3'd3:    b = arg[23:16];
         3'd4:    b = arg[15:8];
         3'd5:    b = arg[7:0];
         3'd6:    b = chk;
         default: b = FILL_BYTE;
      endcase
      return b;
   endfunction

endpackage

>>> hw/rtl/sdh_step.sv
module sdh_step (
   input  sdh_pkg::state_type st,
   input  logic [1:0]         mode,
   input  logic [31:0]        block_number,
   input  logic [7:0]         card_byte,
   input  logic [7:0]         retries,
   output sdh_pkg::state_type st_in,
   output sdh_pkg::rsp_type   rsp_in,
   output logic               has_rsp
);
   import sdh_pkg::*;

   logic [9:0]  bc_n;
   logic [7:0]  lim;
   logic        poll_done;
   logic [7:0]  poll_r;
   logic [7:0]  echo_exp;
   logic [22:0] hc_sum;
   logic [32:0] hc_cap;
   logic [21:0] csd_hc9;
   logic [2:0]  sc_mult;
   logic [3:0]  sc_bl;
   logic [31:0] sc_base;
   logic [31:0] sc_cap;

   assign bc_n = st.byte_count + 10'd1;
   assign lim  = (retries == 8'd0) ? 8'd1 : retries;

   always_comb begin
      case (st.byte_count[1:0])
         2'd0:    echo_exp = ARG_CMD8[31:24];
         2'd1:    echo_exp = ARG_CMD8[23:16];
         2'd2:    echo_exp = ARG_CMD8[15:8];
         default: echo_exp = ARG_CMD8[7:0];
      endcase
   end

   // csd size decode
   always_comb begin
      csd_hc9 = st.csd | {14'd0, card_byte};
      hc_sum  = {1'b0, csd_hc9} + 23'd1;
      hc_cap  = {hc_sum, 10'd0};
      sc_mult = {st.csd[17:16], card_byte[7]};
      sc_bl   = st.csd[15:12];
      sc_base = ({20'd0, st.csd[11:0]} + 32'd1) << ({1'b0, sc_mult} + 4'd2);
      if (sc_bl >= 4'd9) sc_cap = sc_base << (sc_bl - 4'd9);
      else               sc_cap = sc_base >> (4'd9 - sc_bl);
   end

   always_comb begin
      if (card_byte != FILL_BYTE) begin
         poll_done = 1'b1;
         poll_r    = card_byte;
      end else if (st.retry_count < lim) begin
         poll_done = 1'b0;
         poll_r    = FILL_BYTE;
      end else begin
         poll_done = 1'b1;
         poll_r    = FILL_BYTE;
      end
   end

   always_comb begin
      st_in   = st;
      rsp_in  = '0;
      has_rsp = 1'b0;
      case (mode)
         MODE_INIT: begin
            has_rsp             = 1'b1;
            st_in.phase         = PH_DUMMY;
            st_in.byte_count    = '0;
            rsp_in.send_byte    = FILL_BYTE;
            rsp_in.send_valid   = 1'b1;
            rsp_in.chip_select  = 1'b1;
         end
         MODE_READ: begin
            has_rsp           = 1'b1;
            st_in.phase       = PH_READ_TX;
            st_in.byte_count  = '0;
            st_in.argument    = (st.card_kind == KIND_SC) ?
                                {block_number[22:0], 9'd0} : block_number;
            rsp_in.send_byte  = FILL_BYTE;
            rsp_in.send_valid = 1'b1;
         end
         MODE_BYTE: begin
            if (st.phase != PH_IDLE) begin
               has_rsp = 1'b1;
               rsp_in.send_byte  = FILL_BYTE;
               rsp_in.send_valid = 1'b1;
               case (st.phase)
                  PH_DUMMY: begin
                     st_in.byte_count = bc_n;
                     if (bc_n < 10'(DUMMY_BYTES)) begin
                        rsp_in.chip_select = 1'b1;
                     end else begin
                        st_in.phase      = PH_CMD0_TX;
                        st_in.byte_count = '0;
                        st_in.argument   = '0;
                     end
                  end
                  PH_CMD0_TX, PH_CMD8_TX, PH_CMD55_TX, PH_ACMD41_TX, PH_CMD9_TX,
                  PH_READ_TX: begin
                     st_in.byte_count = bc_n;
                     if (bc_n < 10'(FRAME_BYTES)) begin
                        rsp_in.send_byte = frame_byte(st.phase, bc_n[2:0], st.argument);
                     end else begin
                        st_in.retry_count = 8'd1;
                        case (st.phase)
                           PH_CMD0_TX:   st_in.phase = PH_CMD0_RSP;
                           PH_CMD8_TX:   st_in.phase = PH_CMD8_RSP;
                           PH_CMD55_TX:  st_in.phase = PH_CMD55_RSP;
                           PH_ACMD41_TX: st_in.phase = PH_ACMD41_RSP;
                           PH_CMD9_TX:   st_in.phase = PH_CMD9_RSP;
                           default:      st_in.phase = PH_READ_RSP;
                        endcase
                     end
                  end
                  PH_CMD0_RSP, PH_CMD8_RSP, PH_ACMD41_RSP, PH_CMD9_RSP,
                  PH_READ_RSP: begin
                     if (!poll_done) begin
                        st_in.retry_count = st.retry_count + 8'd1;
                     end else begin
                        case (st.phase)
                           PH_CMD0_RSP: begin
                              if (poll_r == FILL_BYTE) begin
                                 st_in.card_kind = KIND_ERROR;
                                 st_in.phase     = PH_IDLE;
                                 st_in.byte_count = '0;
                                 rsp_in.send_byte  = '0;
                                 rsp_in.send_valid = 1'b0;
                                 rsp_in.done_res   = 1'b1;
                                 rsp_in.status     = ST_ABSENT;
                              end else begin
                                 st_in.phase      = PH_CMD8_TX;
                                 st_in.byte_count = '0;
                                 st_in.argument   = ARG_CMD8;
                              end
                           end
                           PH_CMD8_RSP: begin
                              if (poll_r == RSP_ILLEGAL) begin
                                 st_in.card_kind  = KIND_SC;
                                 st_in.phase      = PH_CMD55_TX;
                                 st_in.byte_count = '0;
                                 st_in.argument   = '0;
                              end else if (poll_r == RSP_IDLE) begin
                                 st_in.phase      = PH_CMD8_ECHO;
                                 st_in.byte_count = '0;
                              end else begin
                                 st_in.card_kind   = KIND_ERROR;
                                 st_in.phase       = PH_IDLE;
                                 st_in.byte_count  = '0;
                                 rsp_in.send_byte  = '0;
                                 rsp_in.send_valid = 1'b0;
                                 rsp_in.done_res   = 1'b1;
                                 rsp_in.status     = ST_CARD_ERR;
                              end
                           end
                           PH_ACMD41_RSP: begin
                              st_in.phase      = (poll_r == RSP_IDLE) ? PH_CMD55_TX :
                                                 PH_CMD9_TX;
                              st_in.byte_count = '0;
                              st_in.argument   = '0;
                           end
                           PH_CMD9_RSP: begin
                              if (poll_r != 8'd0) begin
                                 st_in.card_kind   = KIND_ERROR;
                                 st_in.phase       = PH_IDLE;
                                 st_in.byte_count  = '0;
                                 rsp_in.send_byte  = '0;
                                 rsp_in.send_valid = 1'b0;
                                 rsp_in.done_res   = 1'b1;
                                 rsp_in.status     = ST_CARD_ERR;
                              end else begin
                                 st_in.phase = PH_CSD_WAIT;
                              end
                           end
                           default: begin
                              if (poll_r != 8'd0) begin
                                 st_in.phase        = PH_IDLE;
                                 st_in.byte_count   = '0;
                                 rsp_in.send_byte   = '0;
                                 rsp_in.send_valid  = 1'b0;
                                 rsp_in.done_res    = 1'b1;
                                 rsp_in.status      = ST_REJECTED;
                                 rsp_in.reject_code = poll_r;
                              end else begin
                                 st_in.phase = PH_READ_WAIT;
                              end
                           end
                        endcase
                     end
                  end
                  PH_CMD8_ECHO: begin
                     if (card_byte != echo_exp) begin
                        st_in.card_kind   = KIND_ERROR;
                        st_in.phase       = PH_IDLE;
                        st_in.byte_count  = '0;
                        rsp_in.send_byte  = '0;
                        rsp_in.send_valid = 1'b0;
                        rsp_in.done_res   = 1'b1;
                        rsp_in.status     = ST_CARD_ERR;
                     end else begin
                        st_in.byte_count = bc_n;
                        if (bc_n >= 10'd4) begin
                           st_in.card_kind  = KIND_HC;
                           st_in.phase      = PH_CMD55_TX;
                           st_in.byte_count = '0;
                           st_in.argument   = '0;
                        end
                     end
                  end
                  PH_CMD55_RSP: begin
                     if (card_byte != FILL_BYTE) begin
                        st_in.phase      = PH_ACMD41_TX;
                        st_in.byte_count = '0;
                        st_in.argument   = ARG_ACMD41;
                     end
                  end
                  PH_CSD_WAIT: begin
                     if (card_byte != FILL_BYTE) begin
                        st_in.phase      = PH_CSD_DATA;
                        st_in.byte_count = '0;
                     end
                  end
                  PH_CSD_DATA: begin
                     if (st.byte_count == 10'd0) begin
                        st_in.card_kind = card_byte[6] ? KIND_HC : KIND_SC;
                        st_in.csd       = '0;
                     end else if (st.byte_count == 10'd14) begin
                        if (card_byte[5] || card_byte[4]) st_in.protect = 1'b1;
                     end else if (st.card_kind == KIND_HC) begin
                        case (st.byte_count)
                           10'd7: st_in.csd = {card_byte[5:0], 16'd0};
                           10'd8: st_in.csd = st.csd | {6'd0, card_byte, 8'd0};
                           10'd9: begin
                              st_in.csd      = csd_hc9;
                              st_in.capacity = hc_cap[32] ? 32'hFFFF_FFFF : hc_cap[31:0];
                           end
                           default: ;
                        endcase
                     end else begin
                        case (st.byte_count)
                           10'd5: st_in.csd = {6'd0, card_byte[3:0], 12'd0};
                           10'd6: st_in.csd = st.csd | {10'd0, card_byte[1:0], 10'd0};
                           10'd7: st_in.csd = st.csd | {12'd0, card_byte, 2'd0};
                           10'd8: st_in.csd = st.csd | {20'd0, card_byte[7:6]};
                           10'd9: st_in.csd = st.csd | {4'd0, card_byte[1:0], 16'd0};
                           10'd10: st_in.capacity = sc_cap;
                           default: ;
                        endcase
                     end
                     st_in.byte_count = bc_n;
                     if (bc_n >= 10'(CSD_BYTES)) begin
                        st_in.phase       = PH_IDLE;
                        st_in.byte_count  = '0;
                        rsp_in.send_byte  = '0;
                        rsp_in.send_valid = 1'b0;
                        rsp_in.done_res   = 1'b1;
                        rsp_in.status     = ST_OK;
                     end
                  end
                  PH_READ_WAIT: begin
                     if (card_byte == START_TOKEN) begin
                        st_in.phase      = PH_READ_DATA;
                        st_in.byte_count = '0;
                     end
                  end
                  PH_READ_DATA: begin
                     rsp_in.data_byte  = card_byte;
                     rsp_in.data_valid = 1'b1;
                     st_in.byte_count  = bc_n;
                     if (bc_n >= 10'(BLOCK_BYTES)) begin
                        rsp_in.last      = 1'b1;
                        st_in.phase      = PH_READ_CRC;
                        st_in.byte_count = '0;
                     end
                  end
                  PH_READ_CRC: begin
                     st_in.byte_count = bc_n;
                     if (bc_n >= 10'(CRC_BYTES)) begin
                        st_in.phase       = PH_IDLE;
                        st_in.byte_count  = '0;
                        rsp_in.send_byte  = '0;
                        rsp_in.send_valid = 1'b0;
                        rsp_in.done_res   = 1'b1;
                        rsp_in.status     = ST_OK;
                     end
                  end
                  default: begin
                     st_in.phase       = PH_IDLE;
                     rsp_in.send_byte  = '0;
                     rsp_in.send_valid = 1'b0;
                  end
               endcase
            end
         end
         default: ;
      endcase
      rsp_in.card_kind       = st_in.card_kind;
      rsp_in.capacity_blocks = st_in.capacity;
      rsp_in.write_protected = st_in.protect;
   end

endmodule

>>> hw/rtl/sd_spi_host_init_and_read_core.sv
// an accepted request transaction's response, if any, is registered and shown on rsp_*,
// via the skid register while stalled; throughput: one transaction per cycle while
// req_stall is low; the sequencer step is one pass of logic from the state register and
// the request ports into the response register; a two-entry output (response register
// plus skid register) keeps req_stall low while one response waits; reset clears the
// sequencer state, both valid flags and sets the response retry limit back to 10
module sd_spi_host_init_and_read_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_block_number,
   input  logic [7:0]  req_card_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_send_byte,
   output logic        rsp_send_valid,
   output logic        rsp_chip_select,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_data_valid,
   output logic        rsp_last,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_reject_code,
   output logic [1:0]  rsp_card_kind,
   output logic [31:0] rsp_capacity_blocks,
   output logic        rsp_write_protected
);
   import sdh_pkg::*;

   // sequencer state and retry limit
   state_type  state_ff;
   state_type  state_in;
   logic [7:0] retries_ff;
   logic [7:0] retries_in;

   // output register and skid register
   rsp_type out_ff;
   rsp_type out_in;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type skid_ff;
   rsp_type skid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;

   rsp_type step_rsp;
   state_type step_state;
   logic    step_has;
   logic    accept;
   logic    push;
   logic    pop;

   sdh_step u_step (
      .st           (state_ff),
      .mode         (req_mode),
      .block_number (req_block_number),
      .card_byte    (req_card_byte),
      .retries      (retries_ff),
      .st_in        (step_state),
      .rsp_in       (step_rsp),
      .has_rsp      (step_has)
   );

   // only a full skid register holds off new transactions
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && step_has;
   assign pop       = out_valid_ff && !rsp_stall;

   always_comb begin
      state_in   = accept ? step_state : state_ff;
      retries_in = csr_write_enable ? csr_write_data : retries_ff;
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop || !out_valid_ff) begin
         // output slot free: drain skid first, else take the new response
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in       = step_rsp;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         // output held by stall, park the response
         skid_in       = step_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         retries_ff    <= RETRIES_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         retries_ff    <= retries_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_send_byte       = out_ff.send_byte;
   assign rsp_send_valid      = out_ff.send_valid;
   assign rsp_chip_select     = out_ff.chip_select;
   assign rsp_data_byte       = out_ff.data_byte;
   assign rsp_data_valid      = out_ff.data_valid;
   assign rsp_last            = out_ff.last;
   assign rsp_done_res        = out_ff.done_res;
   assign rsp_status          = out_ff.status;
   assign rsp_reject_code     = out_ff.reject_code;
   assign rsp_card_kind       = out_ff.card_kind;
   assign rsp_capacity_blocks = out_ff.capacity_blocks;
   assign rsp_write_protected = out_ff.write_protected;

endmodule

>>> hw/rtl/sdh_checker.sv
module sdh_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_send_valid,
   input logic       rsp_chip_select,
   input logic       rsp_data_valid,
   input logic       rsp_last,
   input logic       rsp_done_res
);

   // response held while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped under stall");

   // nothing shown right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // final block byte carries a data byte
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_data_valid)
      else $error("last without data");

   // a finished operation sends nothing more
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_send_valid && !rsp_data_valid)
      else $error("done with send or data");

   // chip select high only with a filler byte to send
   a_cs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chip_select |-> rsp_send_valid)
      else $error("chip select without send");

endmodule

bind sd_spi_host_init_and_read_core sdh_checker u_sdh_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_send_valid  (rsp_send_valid),
   .rsp_chip_select (rsp_chip_select),
   .rsp_data_valid  (rsp_data_valid),
   .rsp_last        (rsp_last),
   .rsp_done_res    (rsp_done_res)
);
